// File: sv/lru_tag_cache_policy_top_macros.svh
// Assertion macros shared by the LRU tag cache policy RTL.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef LRU_TAG_CACHE_POLICY_TOP_MACROS_SVH
`define LRU_TAG_CACHE_POLICY_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define LTCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LTCP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/ltcp_pkg.sv
// Shared types and constants for the LRU tag cache policy engine.
// No dependencies; used by the controller, the datapath and the top level.
package ltcp_pkg;

    // Default configuration.
    localparam int DEF_WAYS     = 8;
    localparam int DEF_KEY_BITS = 32;

    // Fixed port widths.
    localparam int KEY_W = 32;
    localparam int WAY_W = 3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new lookup key
        logic compare;  // parallel tag compare, pick hit way or victim
        logic update;   // rewrite ages and tag, register the result
    } t_dp_cmd;

endpackage

// File: sv/lru_tag_cache_policy_top.sv
// Fully associative LRU tag and replacement engine, top level.
// Acceptance registers the key; o_valid then follows through the compare-result registers and the result register.
// A new transaction can be accepted in the age-update cycle of the previous one, not in its compare cycle;
// the compare cycle and the age-update cycle share the tag and age registers.
// Reset (synchronous, active low): tags clear to zero, way i gets age i, no result pending.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lru_tag_cache_policy_top #(
    parameter int WAYS     = ltcp_pkg::DEF_WAYS,
    parameter int KEY_BITS = ltcp_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ltcp_pkg::KEY_W-1:0]  i_key,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [ltcp_pkg::WAY_W-1:0]  o_way
);

    ltcp_pkg::t_dp_cmd w_cmd;

    // Sequencing of compare and update cycles.
    ltcp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // Tag and age storage with the result register.
    ltcp_dpath #(
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (i_key),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_way   (o_way)
    );

endmodule

// File: sv/ltcp_ctrl.sv
// Controller state machine for the LRU tag cache policy engine.
// Depends on ltcp_pkg and lru_tag_cache_policy_top_macros.svh.
`include "lru_tag_cache_policy_top_macros.svh"

module ltcp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output ltcp_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    // Only the compare cycle blocks a new transaction; the update cycle
    // overlaps with loading the next key.
    assign busy     = (r_state == ST_CMP);
    assign w_accept = start && !busy;

    // Commands to the datapath.
    always_comb begin
        o_cmd.load    = w_accept;
        o_cmd.compare = (r_state == ST_CMP);
        o_cmd.update  = (r_state == ST_UPD);
    end

    // Next-state logic.
    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = w_accept ? ST_CMP : ST_IDLE;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = w_accept ? ST_CMP : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LTCP_ASSERT_NEXT(a_accept_to_cmp, i_clk, i_rst_n, w_accept, r_state == ST_CMP)
    `LTCP_ASSERT_NEXT(a_cmp_to_upd, i_clk, i_rst_n, r_state == ST_CMP, r_state == ST_UPD)

endmodule

// File: sv/ltcp_dpath.sv
// Datapath of the LRU tag cache policy engine: tag and age registers,
// parallel compare, age update and result register. Depends on ltcp_pkg
// and lru_tag_cache_policy_top_macros.svh.
`include "lru_tag_cache_policy_top_macros.svh"

module ltcp_dpath #(
    parameter int WAYS     = ltcp_pkg::DEF_WAYS,
    parameter int KEY_BITS = ltcp_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ltcp_pkg::t_dp_cmd           i_cmd,
    input  logic [ltcp_pkg::KEY_W-1:0]  i_key,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [ltcp_pkg::WAY_W-1:0]  o_way
);

    localparam int IW = $clog2(WAYS);

    logic [KEY_BITS-1:0] r_tag [WAYS];
    logic [KEY_BITS-1:0] n_tag [WAYS];
    logic [IW-1:0]       r_age [WAYS];
    logic [IW-1:0]       n_age [WAYS];

    logic [KEY_BITS-1:0] r_key;
    logic                r_hit;
    logic [IW-1:0]       r_pick;
    logic [IW-1:0]       r_hit_age;

    logic                r_out_valid;
    logic                r_out_hit;
    logic [ltcp_pkg::WAY_W-1:0] r_out_way;

    logic [WAYS-1:0]     w_match;
    logic [IW-1:0]       w_hit_idx;
    logic [IW-1:0]       w_vic_idx;
    logic [WAYS-1:0]     w_age_seen;

    // Parallel tag compare; the highest matching way wins, and the way
    // holding the oldest rank is the victim on a miss.
    always_comb begin
        w_hit_idx = '0;
        w_vic_idx = '0;
        for (int i = 0; i < WAYS; i++) begin
            w_match[i] = (r_tag[i] == r_key);
            if (w_match[i]) begin
                w_hit_idx = IW'(i);
            end
            if (r_age[i] == IW'(WAYS - 1)) begin
                w_vic_idx = IW'(i);
            end
        end
    end

    // Age and tag update for the picked way.
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            n_tag[i] = r_tag[i];
            n_age[i] = r_age[i];
            if (r_hit) begin
                if (r_age[i] < r_hit_age) begin
                    n_age[i] = IW'(r_age[i] + 1'b1);
                end
            end else begin
                n_age[i] = IW'(r_age[i] + 1'b1);
            end
            if (IW'(i) == r_pick) begin
                n_age[i] = '0;
                if (!r_hit) begin
                    n_tag[i] = r_key;
                end
            end
        end
    end

    // Key capture and compare results; payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= KEY_BITS'(i_key);
        end
        if (i_cmd.compare) begin
            r_hit     <= |w_match;
            r_pick    <= (|w_match) ? w_hit_idx : w_vic_idx;
            r_hit_age <= r_age[w_hit_idx];
        end
    end

    // Tag and age state; reset gives zero tags and age equal to way number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WAYS; i++) begin
                r_tag[i] <= '0;
                r_age[i] <= IW'(i);
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < WAYS; i++) begin
                r_tag[i] <= n_tag[i];
                r_age[i] <= n_age[i];
            end
        end
    end

    // Result register: one strobe per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_hit <= r_hit;
            r_out_way <= ltcp_pkg::WAY_W'(r_pick);
        end
    end

    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;
    assign o_way   = r_out_way;

    // Every rank is held by exactly one way.
    always_comb begin
        w_age_seen = '0;
        for (int k = 0; k < WAYS; k++) begin
            for (int i = 0; i < WAYS; i++) begin
                if (r_age[i] == IW'(k)) begin
                    w_age_seen[k] = 1'b1;
                end
            end
        end
    end

    `LTCP_ASSERT_IMPL(a_ages_perm, i_clk, i_rst_n, 1'b1, &w_age_seen)
    `LTCP_ASSERT_IMPL(a_pick_youngest, i_clk, i_rst_n, r_out_valid, r_age[r_pick] == '0)
    `LTCP_ASSERT_NEXT(a_fill_tag, i_clk, i_rst_n, i_cmd.update && !r_hit, r_tag[$past(r_pick)] == $past(r_key))

endmodule
